[hw/rtl/sphere_grid_edge_generator_core_macros.svh]
// Assertion macros shared by the sphere grid edge generator RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef SPHERE_GRID_EDGE_GENERATOR_CORE_MACROS_SVH
`define SPHERE_GRID_EDGE_GENERATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a consequent in the same cycle as its antecedent
`define SGEG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check a consequent in the cycle after its antecedent
`define SGEG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SGEG_ASSERT_NOW(lbl, ante, cons, msg)
`define SGEG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/sgeg_pkg.sv]
// Types, constants and helpers for the sphere grid edge generator.
// No dependencies; used by the interfaces, the sequencer and the top level.
package sgeg_pkg;

  localparam int unsigned PT_W   = 13;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned NUM_W  = 14;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CNT_W-1:0] MAX_LAT  = 7'd64;
  localparam logic [CNT_W-1:0] MAX_LONG = 7'd64;
  localparam logic [CNT_W-1:0] LAT_RST  = 7'd5;
  localparam logic [CNT_W-1:0] LONG_RST = 7'd8;

  // Derived values for the reset grid
  localparam logic [PT_W-1:0]  SOUTH_RST    = PT_W'(1 + 5 * 8);
  localparam logic [NUM_W-1:0] LAST_IDX_RST = NUM_W'(3 * 5 * 8 - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG = 1'd1;

  // Edge kind codes
  localparam logic [KIND_W-1:0] KIND_VERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HORZ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIAG = 2'd2;

  typedef enum logic [1:0] {
    PH_VERT = 2'd0,
    PH_HORZ = 2'd1,
    PH_DIAG = 2'd2
  } phase_t;

  typedef struct packed {
    logic [PT_W-1:0]   point_a;
    logic [PT_W-1:0]   point_b;
    logic [KIND_W-1:0] edge_kind;
    logic [NUM_W-1:0]  edge_number;
    logic              last_edge;
  } edge_t;

  // Control from the top level to the sequencer
  typedef struct packed {
    logic step;
    logic restart;
    logic clear;
  } seq_ctrl_t;

  // Saturate a count register into 1..maxv
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] maxv);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = 7'd1;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[hw/rtl/sgeg_if.sv]
// Valid/ready channel interfaces for the sphere grid edge generator.
// Depends on sgeg_pkg for field widths.
interface sgeg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface sgeg_out_if;
  logic                             valid;
  logic                             ready;
  logic [sgeg_pkg::PT_W-1:0]        point_a;
  logic [sgeg_pkg::PT_W-1:0]        point_b;
  logic [sgeg_pkg::KIND_W-1:0]      edge_kind;
  logic [sgeg_pkg::NUM_W-1:0]       edge_number;
  logic                             last_edge;

  modport source (output valid, output point_a, output point_b, output edge_kind,
                  output edge_number, output last_edge, input ready);
  modport sink   (input valid, input point_a, input point_b, input edge_kind,
                  input edge_number, input last_edge, output ready);
endinterface

[hw/rtl/sgeg_seq.sv]
// Edge sequencer: walk state for the grid and the edge it produces next.
// Depends on sgeg_pkg and the assertion macros header.
`include "sphere_grid_edge_generator_core_macros.svh"

module sgeg_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sgeg_pkg::seq_ctrl_t             ctrl,
  input  logic [sgeg_pkg::CNT_W-1:0]      lat_eff,
  input  logic [sgeg_pkg::CNT_W-1:0]      long_eff,
  input  logic [sgeg_pkg::PT_W-1:0]       south,
  input  logic [sgeg_pkg::NUM_W-1:0]      last_idx,
  output sgeg_pkg::edge_t                 res
);

  sgeg_pkg::phase_t                 phase_r, phase_nxt;
  logic [sgeg_pkg::CNT_W-1:0]       outer_r, outer_nxt;
  logic [sgeg_pkg::CNT_W-1:0]       inner_r, inner_nxt;
  logic [sgeg_pkg::PT_W-1:0]        cur_r, cur_nxt;
  logic [sgeg_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [sgeg_pkg::NUM_W-1:0]       edge_cnt_r, edge_cnt_nxt;

  // State as seen by this request, after any restart
  logic                             phase_ok;
  logic                             go_first;
  sgeg_pkg::phase_t                 ph;
  logic [sgeg_pkg::CNT_W-1:0]       outer;
  logic [sgeg_pkg::CNT_W-1:0]       inner;
  logic [sgeg_pkg::PT_W-1:0]        cur;
  logic [sgeg_pkg::COL_W-1:0]       col;
  logic [sgeg_pkg::NUM_W-1:0]       cnt;

  always_comb begin
    phase_ok = (phase_r == sgeg_pkg::PH_VERT) || (phase_r == sgeg_pkg::PH_HORZ) ||
               (phase_r == sgeg_pkg::PH_DIAG);
    go_first = ctrl.restart || !phase_ok;
    ph       = go_first ? sgeg_pkg::PH_VERT : phase_r;
    outer    = go_first ? '0 : outer_r;
    inner    = go_first ? '0 : inner_r;
    cur      = go_first ? '0 : cur_r;
    col      = go_first ? '0 : col_r;
    cnt      = go_first ? '0 : edge_cnt_r;
  end

  // Row base: one shared multiply, ring index times longitude count
  logic [sgeg_pkg::CNT_W-1:0]       mul_sel;
  logic [2*sgeg_pkg::CNT_W-1:0]     prod;
  logic [sgeg_pkg::PT_W-1:0]        row_base;

  always_comb begin
    mul_sel  = (ph == sgeg_pkg::PH_HORZ) ? outer : inner;
    prod     = mul_sel * long_eff;
    row_base = prod[sgeg_pkg::PT_W-1:0] + 13'd1;
  end

  // Edge endpoints and the walk's next position
  logic [sgeg_pkg::CNT_W-1:0]       inner_p1;
  logic [sgeg_pkg::CNT_W-1:0]       outer_p1;
  logic [sgeg_pkg::CNT_W-1:0]       col_p1;
  logic [sgeg_pkg::COL_W-1:0]       ncol;
  logic [sgeg_pkg::PT_W-1:0]        pa, pb;
  logic [sgeg_pkg::KIND_W-1:0]      kind;
  logic                             last;

  always_comb begin
    inner_p1 = inner + 7'd1;
    outer_p1 = outer + 7'd1;
    col_p1   = {1'b0, col} + 7'd1;
    ncol     = (col_p1 >= long_eff) ? '0 : col_p1[sgeg_pkg::COL_W-1:0];
    last     = (cnt >= last_idx);

    phase_nxt    = ph;
    outer_nxt    = outer;
    inner_nxt    = inner_p1;
    cur_nxt      = cur;
    col_nxt      = col;
    pa           = '0;
    pb           = '0;
    kind         = sgeg_pkg::KIND_VERT;

    case (ph)
      sgeg_pkg::PH_VERT: begin
        // Meridian: pole, down each ring, to the other pole
        kind = sgeg_pkg::KIND_VERT;
        pa   = (inner == '0) ? '0 : cur;
        if (inner == lat_eff) begin
          pb = south;
        end else if (inner == '0) begin
          pb = {6'd0, outer_p1};
        end else begin
          pb = cur + {6'd0, long_eff};
        end
        cur_nxt = pb;
        if (inner_p1 > lat_eff) begin
          inner_nxt = '0;
          outer_nxt = outer_p1;
          if (outer_p1 >= long_eff) begin
            outer_nxt = '0;
            phase_nxt = sgeg_pkg::PH_HORZ;
          end
        end
      end
      sgeg_pkg::PH_HORZ: begin
        // Ring: close back on the first point of the ring
        kind = sgeg_pkg::KIND_HORZ;
        pa   = row_base + {6'd0, inner};
        pb   = (inner_p1 >= long_eff) ? row_base : pa + 13'd1;
        if (inner_p1 >= long_eff) begin
          inner_nxt = '0;
          outer_nxt = outer_p1;
          if (outer_p1 >= lat_eff) begin
            outer_nxt = '0;
            col_nxt   = '0;
            phase_nxt = sgeg_pkg::PH_DIAG;
          end
        end
      end
      sgeg_pkg::PH_DIAG: begin
        // Diagonal: one ring down, one column on, wrap the column
        kind    = sgeg_pkg::KIND_DIAG;
        pa      = row_base + {7'd0, col};
        pb      = row_base + {6'd0, long_eff} + {7'd0, ncol};
        col_nxt = ncol;
        if ({1'b0, inner_p1} + 8'd1 >= {1'b0, lat_eff}) begin
          inner_nxt = '0;
          outer_nxt = outer_p1;
          col_nxt   = outer_p1[sgeg_pkg::COL_W-1:0];
        end
      end
      default: begin
        phase_nxt = sgeg_pkg::PH_VERT;
      end
    endcase

    edge_cnt_nxt = cnt + 14'd1;

    res.point_a     = pa;
    res.point_b     = pb;
    res.edge_kind   = kind;
    res.edge_number = cnt;
    res.last_edge   = last;
  end

  // Advance the walk on each request; drop back to the first edge on clear or wrap
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear || (ctrl.step && last)) begin
      phase_r    <= sgeg_pkg::PH_VERT;
      outer_r    <= '0;
      inner_r    <= '0;
      cur_r      <= '0;
      col_r      <= '0;
      edge_cnt_r <= '0;
    end else if (ctrl.step) begin
      phase_r    <= phase_nxt;
      outer_r    <= outer_nxt;
      inner_r    <= inner_nxt;
      cur_r      <= cur_nxt;
      col_r      <= col_nxt;
      edge_cnt_r <= edge_cnt_nxt;
    end
  end

  `SGEG_ASSERT_NEXT(a_last_wraps, ctrl.step && res.last_edge, (edge_cnt_r == '0) && (phase_r == sgeg_pkg::PH_VERT), "walk did not return to the first edge after the last one")
  `SGEG_ASSERT_NEXT(a_count_steps, ctrl.step && !ctrl.clear && !res.last_edge, edge_cnt_r == $past(res.edge_number) + 14'd1, "edge count did not advance by one")
  `SGEG_ASSERT_NOW(a_ring_not_pole, ctrl.step && (res.edge_kind == sgeg_pkg::KIND_HORZ), res.point_a != '0, "ring edge starts at the north pole")

endmodule

[hw/rtl/sphere_grid_edge_generator_core.sv]
// Sphere grid edge generator top level: config registers, request and result stages.
// Depends on sgeg_pkg, sgeg_if.sv, sgeg_seq and the assertion macros header.
//
// Each request on in_ch yields one edge of a latitude/longitude triangle grid on out_ch:
// first the meridian edges, then the ring edges, then the diagonals, 3*L*N in all, with
// last_edge on the final one; restart=1 begins again at edge 0. While out_ch.ready is
// high the block takes one request per clock and gives one result per clock. A taken
// request is held in the request register until the result register is free, and its
// result is then loaded into the result register. The grid walk sits in one short step
// between the two registers, with a single 7x7 multiply for the ring base. While a
// result waits, the request register holds one more request and then drops in_ch.ready
// until the result is taken. Writing lat_count or long_count (values clamped into 1..64,
// 0 acting as 1) returns the walk to edge 0; write only while no request is in flight.
`include "sphere_grid_edge_generator_core_macros.svh"

module sphere_grid_edge_generator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  sgeg_in_if.sink                             in_ch,
  sgeg_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [sgeg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgeg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Configuration registers, held already clamped
  logic [sgeg_pkg::CNT_W-1:0]   lat_r, long_r;
  logic [sgeg_pkg::PT_W-1:0]    south_r;
  logic [sgeg_pkg::NUM_W-1:0]   last_idx_r;
  logic [2*sgeg_pkg::CNT_W-1:0] grid_pts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r  <= sgeg_pkg::LAT_RST;
      long_r <= sgeg_pkg::LONG_RST;
    end else if (cfg_we) begin
      if (cfg_index == sgeg_pkg::REG_LAT) begin
        lat_r <= sgeg_pkg::clamp_count(cfg_wdata, sgeg_pkg::MAX_LAT);
      end
      if (cfg_index == sgeg_pkg::REG_LONG) begin
        long_r <= sgeg_pkg::clamp_count(cfg_wdata, sgeg_pkg::MAX_LONG);
      end
    end
  end

  // South pole index and final edge number follow the grid size
  assign grid_pts = lat_r * long_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      south_r    <= sgeg_pkg::SOUTH_RST;
      last_idx_r <= sgeg_pkg::LAST_IDX_RST;
    end else begin
      south_r    <= grid_pts[sgeg_pkg::PT_W-1:0] + 13'd1;
      last_idx_r <= {grid_pts[sgeg_pkg::PT_W-1:0], 1'b0} + {1'b0, grid_pts[sgeg_pkg::PT_W-1:0]}
                    - 14'd1;
    end
  end

  // Request register
  logic in_valid_r;
  logic in_restart_r;
  logic out_valid_r;
  logic advance;
  logic in_take;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_restart_r <= in_ch.restart;
    end
  end

  // Grid walk
  sgeg_pkg::seq_ctrl_t ctrl;
  sgeg_pkg::edge_t     step_res;

  assign ctrl.step    = advance;
  assign ctrl.restart = in_restart_r;
  assign ctrl.clear   = cfg_we;

  sgeg_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .lat_eff  (lat_r),
    .long_eff (long_r),
    .south    (south_r),
    .last_idx (last_idx_r),
    .res      (step_res)
  );

  // Result register
  sgeg_pkg::edge_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= step_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.point_a     = out_data_r.point_a;
  assign out_ch.point_b     = out_data_r.point_b;
  assign out_ch.edge_kind   = out_data_r.edge_kind;
  assign out_ch.edge_number = out_data_r.edge_number;
  assign out_ch.last_edge   = out_data_r.last_edge;

  `SGEG_ASSERT_NEXT(a_req_held, in_valid_r && !advance, in_valid_r && $stable(in_restart_r), "waiting request lost or changed")
  `SGEG_ASSERT_NEXT(a_result_loaded, advance, out_valid_r, "advanced request produced no result")
  `SGEG_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_ch.ready, !advance, "result overwritten while held")

endmodule

[tb/sv/sphere_grid_edge_generator_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the sphere grid edge generator: a negedge driver and
// ready generator, a posedge scoreboard with its own model of the grid walk.
// Depends on sgeg_pkg, sgeg_if.sv and the sphere_grid_edge_generator_core RTL.
module sphere_grid_edge_generator_core_tb;
  import sgeg_pkg::*;

  typedef struct {
    logic restart;
    bit   drain;
  } edge_req_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sgeg_in_if  in_ch ();
  sgeg_out_if out_ch ();

  sphere_grid_edge_generator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Requests waiting to be offered and edges waiting to come out
  edge_req_t requests_to_send[$];
  edge_t     edges_due[$];

  // Handshake bookkeeping shared between the clocked processes
  bit in_busy;
  bit req_taken;
  bit result_taken;
  bit src_idling;
  bit sink_idling;
  bit hold_off_req;
  int gap_left;
  int stall_left;
  int hold_left;

  int errors;
  int n_requests;
  int n_results;
  int n_wraps;
  int n_settings;

  // Shadow of the registers and the walk state
  logic [CFG_DATA_W-1:0] lat_shadow;
  logic [CFG_DATA_W-1:0] long_shadow;
  logic [1:0]            walk_phase;
  int unsigned           walk_outer;
  int unsigned           walk_inner;
  int unsigned           walk_point;
  int unsigned           walk_column;
  int unsigned           walk_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("sphere_grid_edge_generator_core_tb failed");
    $finish;
  end

  function automatic void restart_walk();
    walk_phase  = PH_VERT;
    walk_outer  = 0;
    walk_inner  = 0;
    walk_point  = 0;
    walk_column = 0;
    walk_count  = 0;
  endfunction

  // Advance the grid walk by one edge and return that edge
  task automatic walk_grid(input logic restart, output edge_t e);
    int unsigned nl, nn, total, a, b, kind, base, ncol;
    bit wrap;
    nl = (lat_shadow == 0) ? 1 : ((lat_shadow > MAX_LAT) ? int'(MAX_LAT) : lat_shadow);
    nn = (long_shadow == 0) ? 1 : ((long_shadow > MAX_LONG) ? int'(MAX_LONG) : long_shadow);
    total = 3 * nl * nn;
    a = 0;
    b = 0;
    if (restart || walk_phase > PH_DIAG) restart_walk();
    case (walk_phase)
      PH_VERT: begin
        kind = KIND_VERT;
        a = (walk_inner == 0) ? 0 : walk_point;
        if (walk_inner == nl) b = 1 + nl * nn;
        else if (walk_inner == 0) b = walk_outer + 1;
        else b = walk_point + nn;
        walk_point = b;
        walk_inner++;
        if (walk_inner > nl) begin
          walk_inner = 0;
          walk_outer++;
          if (walk_outer >= nn) begin
            walk_outer = 0;
            walk_phase = PH_HORZ;
          end
        end
      end
      PH_HORZ: begin
        kind = KIND_HORZ;
        base = 1 + walk_outer * nn;
        a = base + walk_inner;
        b = (walk_inner + 1 >= nn) ? base : a + 1;
        walk_inner++;
        if (walk_inner >= nn) begin
          walk_inner = 0;
          walk_outer++;
          if (walk_outer >= nl) begin
            walk_outer  = 0;
            walk_column = 0;
            walk_phase  = PH_DIAG;
          end
        end
      end
      default: begin
        kind = KIND_DIAG;
        ncol = (walk_column + 1 >= nn) ? 0 : walk_column + 1;
        a = 1 + walk_inner * nn + walk_column;
        b = 1 + (walk_inner + 1) * nn + ncol;
        walk_column = ncol;
        walk_inner++;
        if (walk_inner + 1 >= nl) begin
          walk_inner = 0;
          walk_outer++;
          walk_column = walk_outer;
        end
      end
    endcase
    wrap = (walk_count + 1 >= total);
    e.point_a     = PT_W'(a);
    e.point_b     = PT_W'(b);
    e.edge_kind   = KIND_W'(kind);
    e.edge_number = NUM_W'(walk_count);
    e.last_edge   = wrap;
    if (wrap) restart_walk();
    else walk_count++;
  endtask

  // Scoreboard: check results, model accepted requests and register writes
  always @(posedge clk) begin
    edge_t got, want;
    if (!rst_n) begin
      lat_shadow  = LAT_RST;
      long_shadow = LONG_RST;
      restart_walk();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.point_a     = out_ch.point_a;
        got.point_b     = out_ch.point_b;
        got.edge_kind   = out_ch.edge_kind;
        got.edge_number = out_ch.edge_number;
        got.last_edge   = out_ch.last_edge;
        result_taken = 1'b1;
        n_results++;
        if (edges_due.size() == 0) begin
          $error("result with no request outstanding: edge_number %0d", got.edge_number);
          errors++;
        end else begin
          want = edges_due.pop_front();
          if (got.point_a !== want.point_a) begin
            $error("point_a: expected %0d, got %0d", want.point_a, got.point_a);
            errors++;
          end
          if (got.point_b !== want.point_b) begin
            $error("point_b: expected %0d, got %0d", want.point_b, got.point_b);
            errors++;
          end
          if (got.edge_kind !== want.edge_kind) begin
            $error("edge_kind: expected %0d, got %0d", want.edge_kind, got.edge_kind);
            errors++;
          end
          if (got.edge_number !== want.edge_number) begin
            $error("edge_number: expected %0d, got %0d", want.edge_number, got.edge_number);
            errors++;
          end
          if (got.last_edge !== want.last_edge) begin
            $error("last_edge: expected %0d, got %0d", want.last_edge, got.last_edge);
            errors++;
          end
          if (want.last_edge) n_wraps++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        walk_grid(in_ch.restart, want);
        edges_due.push_back(want);
        req_taken = 1'b1;
        n_requests++;
      end
      if (cfg_we) begin
        if (cfg_index == REG_LAT) lat_shadow = cfg_wdata;
        else if (cfg_index == REG_LONG) long_shadow = cfg_wdata;
        restart_walk();
      end
    end
  end

  // Request driver: offer queued requests with random gaps
  always @(negedge clk) begin
    logic      v_next;
    edge_req_t cur;
    v_next = in_ch.valid;
    if (rst_n) begin
      if (req_taken) begin
        req_taken = 1'b0;
        in_busy   = 1'b0;
        v_next    = 1'b0;
        gap_left  = src_idling ? $urandom_range(0, 6) : 0;
      end
      if (!in_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (requests_to_send.size() != 0 &&
                     !(requests_to_send[0].drain && edges_due.size() != 0)) begin
          cur = requests_to_send.pop_front();
          in_ch.restart <= cur.restart;
          in_busy = 1'b1;
          v_next  = 1'b1;
        end
      end
    end
    in_ch.valid <= v_next;
  end

  // Result ready: random stalls per result, plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = 60;
    end
    if (result_taken) begin
      result_taken = 1'b0;
      stall_left   = sink_idling ? $urandom_range(0, 6) : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hold until every request is out and every edge is back
  task automatic wait_idle();
    while (requests_to_send.size() != 0 || in_busy || edges_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_request(input logic restart, input bit drain);
    edge_req_t r;
    r.restart = restart;
    r.drain   = drain;
    requests_to_send.push_back(r);
  endtask

  task automatic add_random_requests(input int count, input int restart_pct);
    for (int i = 0; i < count; i++)
      add_request($urandom_range(0, 99) < restart_pct, $urandom_range(0, 99) == 0);
  endtask

  initial begin
    int lat_set[10];
    int long_set[10];
    int count_set[10];
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_LAT;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready  = 1'b0;
    src_idling    = 1'b1;
    sink_idling   = 1'b1;
    lat_set   = '{1, 64, 1, 127, 0, 2, 3, 1, 1, 5};
    long_set  = '{1, 1, 64, 127, 0, 3, 2, 1, 1, 8};
    count_set = '{60, 200, 200, 120, 30, 60, 60, 60, 60, 60};
    lat_set[7]  = $urandom_range(1, 8);
    long_set[7] = $urandom_range(1, 8);
    lat_set[8]  = $urandom_range(0, 127);
    long_set[8] = $urandom_range(1, 4);
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset grid: plain steps and restarts, back to back restarts too
    n_settings = 1;
    add_request(1'b0, 1'b0);
    add_request(1'b0, 1'b0);
    add_request(1'b1, 1'b0);
    add_request(1'b0, 1'b0);
    add_request(1'b1, 1'b0);
    add_request(1'b1, 1'b0);
    wait_idle();

    // Rewriting the same value still returns the walk to edge 0
    write_reg(REG_LAT, LAT_RST);
    repeat (3) add_request(1'b0, 1'b0);
    wait_idle();

    // Single longitude: ring edges loop on one point
    write_reg(REG_LAT, 7'd2);
    write_reg(REG_LONG, 7'd1);
    n_settings++;
    repeat (7) add_request(1'b0, 1'b0);
    wait_idle();

    // Single ring: no diagonals, wrap straight after the ring edges
    write_reg(REG_LAT, 7'd1);
    write_reg(REG_LONG, 7'd3);
    n_settings++;
    repeat (9) add_request(1'b0, 1'b0);
    wait_idle();

    // Random phases over a spread of grid sizes
    for (int p = 0; p < 10; p++) begin
      write_reg(REG_LAT, CFG_DATA_W'(lat_set[p]));
      write_reg(REG_LONG, CFG_DATA_W'(long_set[p]));
      n_settings++;
      src_idling  = $urandom_range(0, 2) != 0;
      sink_idling = $urandom_range(0, 2) != 0;
      if (p == 3) begin
        // Long receiver hold-off with the sender pushing flat out
        src_idling = 1'b0;
        @(posedge clk);
        hold_off_req = 1'b1;
      end
      if (p == 5) begin
        // Pause the sender mid-phase until every edge has come back
        add_random_requests(count_set[p] / 2, 2);
        add_request(1'b0, 1'b1);
        add_random_requests(count_set[p] / 2, 2);
      end else begin
        add_random_requests(count_set[p], (p == 8) ? 25 : 2);
      end
      wait_idle();
    end

    src_idling  = 1'b0;
    sink_idling = 1'b0;
    repeat (8) @(posedge clk);
    $display("Ran %0d requests and %0d results over %0d grid settings, %0d full wraps",
             n_requests, n_results, n_settings, n_wraps);
    $display("Covered restarts, rewrites, single ring, single longitude, clamped sizes");
    if (errors == 0 && edges_due.size() == 0) begin
      $display("sphere_grid_edge_generator_core_tb passed");
    end else begin
      $display("sphere_grid_edge_generator_core_tb failed");
    end
    $finish;
  end

endmodule
